[sv/itra_pkg.sv]
// Shared types, constants and helper functions for the integer-to-radix ASCII converter.
// No dependencies; every other file in this block imports this package.
package itra_pkg;

    // Default word width of the converted number.
    localparam int WORD_BITS_DEFAULT = 32;

    // Field widths.
    localparam int BASE_W  = 8;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;

    // Number of quotient bits the divider resolves per cycle.
    localparam int DIV_STEP = 8;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Accepted radix range.
    localparam logic [BASE_W-1:0] BASE_MIN = 8'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 8'd36;

    // Digit values and character codes.
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0]  CHAR_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;

    // Classification of one word, handed from the front to the back.
    typedef struct packed {
        logic               neg;
        logic               special;
        logic [DIGIT_W-1:0] base;
    } itra_ctl_t;

    // Map a digit value to its upper-case ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] code;
        if (d < DIGIT_TEN) begin
            code = CHAR_ZERO + CHAR_W'(d);
        end else begin
            code = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return code;
    endfunction

endpackage

[sv/itra_front.sv]
// Front end: accepts a word, takes its magnitude and flags the single-'0' cases.
// Depends on itra_pkg.
module itra_front import itra_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_BITS-1:0] s_value,
    input  logic                 s_is_signed,
    input  logic [BASE_W-1:0]    s_base,
    output logic                 push_valid,
    input  logic                 push_ready,
    output logic [WORD_BITS-1:0] push_mag,
    output itra_ctl_t            push_ctl
);

    logic neg;
    logic special;

    // A signed word with its top bit set is negative; the most negative value
    // negates to itself, which read as unsigned is the exact magnitude.
    assign neg = s_is_signed & s_value[WORD_BITS-1];
    assign push_mag = neg ? (~s_value + WORD_BITS'(1)) : s_value;

    // Zero or an unsupported radix yields the lone character '0'.
    assign special = (s_value == '0) || (s_base < BASE_MIN) || (s_base > BASE_MAX);

    assign push_ctl.neg     = neg & ~special;
    assign push_ctl.special = special;
    assign push_ctl.base    = s_base[DIGIT_W-1:0];

    // Words pass straight into the queue whenever it has room.
    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

[sv/itra_queue.sv]
// Small first-in first-out queue that decouples the front from the back.
// Depends on itra_pkg for its depth.
module itra_queue import itra_pkg::*; #(
    parameter int WIDTH = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[sv/itra_back.sv]
// Back end: divides the magnitude by the radix, stacks the digits and sends the characters.
// Depends on itra_pkg.
module itra_back import itra_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [WORD_BITS-1:0] q_mag,
    input  itra_ctl_t            q_ctl,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CHAR_W-1:0]    m_char_code,
    output logic                 m_last
);

    // Divider geometry: ITER division steps of DIV_STEP quotient bits each per digit.
    localparam int ITER       = (WORD_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD_BITS   = ITER * DIV_STEP;
    localparam int STEP_CNT_W = (ITER > 1) ? $clog2(ITER) : 1;
    localparam int CNT_W      = $clog2(WORD_BITS + 1);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_DIV  = 4'b0010,
        B_SIGN = 4'b0100,
        B_EMIT = 4'b1000
    } itra_bstate_t;

    itra_bstate_t            state_reg, state_next;
    logic [PAD_BITS-1:0]     quo_reg, quo_next;
    logic [DIGIT_W-1:0]      rem_reg, rem_next;
    logic [DIGIT_W-1:0]      base_reg, base_next;
    logic [STEP_CNT_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;
    logic                    m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]       m_char_code_reg, m_char_code_next;
    logic                    m_last_reg, m_last_next;
    logic [DIGIT_W-1:0]      stk_reg [WORD_BITS];
    logic                    push_en;
    logic                    pop_en;
    logic                    load_zero;
    logic                    out_free;
    logic [DIGIT_W:0]        div_rem;
    logic [PAD_BITS-1:0]     div_quo;

    assign out_free    = !m_valid_reg || m_ready;
    assign q_ready     = (state_reg == B_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_code_reg;
    assign m_last      = m_last_reg;

    // Restoring long division, DIV_STEP quotient bits per cycle.
    always_comb begin
        div_rem = {1'b0, rem_reg};
        div_quo = quo_reg;
        for (int i = 0; i < DIV_STEP; i++) begin
            div_rem = {div_rem[DIGIT_W-1:0], div_quo[PAD_BITS-1]};
            div_quo = {div_quo[PAD_BITS-2:0], 1'b0};
            if (div_rem >= {1'b0, base_reg}) begin
                div_rem    = div_rem - {1'b0, base_reg};
                div_quo[0] = 1'b1;
            end
        end
    end

    // Sequencer: load, divide digit by digit, then emit sign and digits.
    always_comb begin
        state_next       = state_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        base_next        = base_reg;
        step_next        = step_reg;
        cnt_next         = cnt_reg;
        neg_next         = neg_reg;
        m_valid_next     = m_valid_reg & ~m_ready;
        m_char_code_next = m_char_code_reg;
        m_last_next      = m_last_reg;
        push_en          = 1'b0;
        pop_en           = 1'b0;
        load_zero        = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    if (q_ctl.special) begin
                        load_zero  = 1'b1;
                        cnt_next   = CNT_W'(1);
                        neg_next   = 1'b0;
                        state_next = B_EMIT;
                    end else begin
                        quo_next   = PAD_BITS'(q_mag);
                        rem_next   = '0;
                        step_next  = '0;
                        cnt_next   = '0;
                        neg_next   = q_ctl.neg;
                        base_next  = q_ctl.base;
                        state_next = B_DIV;
                    end
                end
            end
            B_DIV: begin
                quo_next  = div_quo;
                rem_next  = div_rem[DIGIT_W-1:0];
                step_next = step_reg + STEP_CNT_W'(1);
                if (step_reg == STEP_CNT_W'(ITER - 1)) begin
                    // One digit is done; push it and start on the quotient.
                    push_en   = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    rem_next  = '0;
                    step_next = '0;
                    if (div_quo == '0) begin
                        state_next = neg_reg ? B_SIGN : B_EMIT;
                    end
                end
            end
            B_SIGN: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_char_code_next = CHAR_MINUS;
                    m_last_next      = 1'b0;
                    state_next       = B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_char_code_next = digit_char(stk_reg[0]);
                    m_last_next      = (cnt_reg == CNT_W'(1));
                    pop_en           = 1'b1;
                    cnt_next         = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = B_IDLE;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            step_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers hold payload only.
    always_ff @(posedge aclk) begin
        quo_reg         <= quo_next;
        rem_reg         <= rem_next;
        base_reg        <= base_next;
        neg_reg         <= neg_next;
        m_char_code_reg <= m_char_code_next;
        m_last_reg      <= m_last_next;
    end

    // Digit stack: digits come out least significant first and leave from the top.
    always_ff @(posedge aclk) begin
        if (load_zero) begin
            stk_reg[0] <= '0;
        end else if (push_en) begin
            stk_reg[0] <= div_rem[DIGIT_W-1:0];
            for (int i = 1; i < WORD_BITS; i++) begin
                stk_reg[i] <= stk_reg[i-1];
            end
        end else if (pop_en) begin
            for (int i = 0; i < WORD_BITS - 1; i++) begin
                stk_reg[i] <= stk_reg[i+1];
            end
        end
    end

endmodule

[sv/integer_to_radix_ascii.sv]
// Top level of the integer-to-radix ASCII converter: front, queue and back.
// Depends on itra_pkg, itra_front, itra_queue and itra_back.
//
// Usage:
//   The s_ channel takes one word per transfer: s_value, s_is_signed and s_base.
//   The m_ channel returns that number's characters, most significant first,
//   one per transfer, with m_last set on the final one. A negative signed value is
//   led by '-'; zero or a radix outside 2 to 36 gives the single character '0'.
//   A word enters a two-entry queue and is popped by the back end, whose
//   single divider resolves 8 quotient bits per cycle for each digit in
//   turn. After the last digit, the sign and the digits leave at one per
//   cycle while the receiver is ready. The back end takes no new word until
//   the last character is in the output register; the special '0' case
//   skips the divider.
//   The front keeps accepting words while the queue has room.
//   Reset (aresetn low, synchronous) empties the queue and drops any word in
//   progress. When the receiver stalls, the output register holds its word
//   and the back end waits; the queue then fills and s_ready falls.
module integer_to_radix_ascii import itra_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_BITS-1:0] s_value,
    input  logic                 s_is_signed,
    input  logic [BASE_W-1:0]    s_base,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CHAR_W-1:0]    m_char_code,
    output logic                 m_last
);

    localparam int CTL_W  = $bits(itra_ctl_t);
    localparam int DATA_W = WORD_BITS + CTL_W;

    logic                 push_valid;
    logic                 push_ready;
    logic [WORD_BITS-1:0] push_mag;
    itra_ctl_t            push_ctl;
    logic                 q_valid;
    logic                 q_ready;
    logic [DATA_W-1:0]    q_in_data;
    logic [DATA_W-1:0]    q_out_data;

    itra_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_is_signed (s_is_signed),
        .s_base      (s_base),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_mag    (push_mag),
        .push_ctl    (push_ctl)
    );

    assign q_in_data = {push_ctl, push_mag};

    itra_queue #(
        .WIDTH (DATA_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (q_in_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_out_data)
    );

    itra_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_mag       (q_out_data[WORD_BITS-1:0]),
        .q_ctl       (itra_ctl_t'(q_out_data[DATA_W-1:WORD_BITS])),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

    // Every character sent is a minus sign, a decimal digit or an upper-case letter.
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_char_code == CHAR_MINUS)
                 || (m_char_code >= CHAR_ZERO && m_char_code <= CHAR_NINE)
                 || (m_char_code >= CHAR_A && m_char_code <= CHAR_Z))
        else $error("character outside the digit set");

    // A minus sign always has digits after it.
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_char_code == CHAR_MINUS) |-> !m_last)
        else $error("minus sign marked as last");

    // The front only stalls when the queue holds words for the back end.
    a_stall_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_valid)
        else $error("input stalled with an empty queue");

    // Reset leaves no word on the output.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule
